/* hw/rtl/scp_pkg.sv */
// Shared types and constants for the sine/cosine polynomial unit.
// No dependencies; the other RTL files refer to this package by scoped names.
package scp_pkg;

    // Signed fixed point, 60 fraction bits, held in 64 bits
    typedef logic signed [63:0] q60_t;

    // Quadrant and batch marker that travel beside the polynomial lanes
    typedef struct packed {
        logic [1:0] quad;
        logic       last;
    } side_t;

    // 1/(2*pi) in Q0.64, truncated
    localparam logic [63:0] INV_TWO_PI = 64'h28BE_60DB_9391_054A;
    // pi/2 in Q60, rounded to nearest
    localparam logic [63:0] HALF_PI    = 64'h1921_FB54_442D_1847;
    localparam logic [31:0] HALF_PI_LO = HALF_PI[31:0];
    localparam logic [28:0] HALF_PI_HI = HALF_PI[60:32];

    localparam q60_t ONE_Q60     = 64'sh1000_0000_0000_0000;
    localparam q60_t NEG_ONE_Q60 = -64'sh1000_0000_0000_0000;

    // Even cosine polynomial, Q60, lowest order first
    localparam q60_t POLY_COEF [8] = '{
        64'sd1152921504606844748,
        -64'sd576460752303307800,
        64'sd48038396024299631,
        -64'sd1601279864309835,
        64'sd28594278246078,
        -64'sd317709838487,
        64'sd2404801474,
        -64'sd12775196
    };

    localparam int POLY_TERMS = 8;

endpackage

/* hw/rtl/sine_cosine_polynomial_unit_top.sv */
// Top level of the quadrant-reduced polynomial sine/cosine unit.
// Instantiates scp_front, scp_mac and scp_round; uses scp_pkg.
//
// Usage:
//   Input channel (in_valid / in_ready) carries one word: angle in radians,
//   signed Q8.24 by default, plus is_last, which marks the end of a batch.
//   Output channel (out_valid / out_ready) carries sine and cosine, signed
//   Q1.30 by default and saturated to +-1.0, plus last_out, a copy of is_last.
//   A word is moved at a rising edge where valid and ready are both high.
// Stages and throughput:
//   21 register stages: 4 for reduction of the angle to a quadrant and two
//   arguments, 2 for squaring, 2 for each of the 7 Horner steps and 1 for
//   rounding into the output register. One angle is taken every cycle unless
//   every stage is full and the output word is not taken; the rate is set by
//   the Horner chain, where every step owns its own 32x32 partial products.
// Reset:
//   rst_n clears every stage valid bit at once; data registers are not reset.
// Stalls:
//   Each stage moves when some stage at or after it is empty or the output
//   word is being taken, so bubbles close up while the output waits and the
//   input keeps accepting until every stage holds a word. Nothing is dropped
//   or repeated.
module sine_cosine_polynomial_unit_top #(
    parameter int ANGLE_FRAC_BITS = 24,
    parameter int OUT_FRAC_BITS   = 30
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [31:0] angle,
    input  logic        is_last,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [31:0] sine,
    output logic [31:0] cosine,
    output logic        last_out
);

    localparam int FRONT_ST = 4;                                   // reduction stages
    localparam int SQ_ST    = FRONT_ST;                            // first squaring stage
    localparam int POLY_ST  = SQ_ST + 2;                           // first Horner stage
    localparam int HORNER   = scp_pkg::POLY_TERMS - 1;             // Horner steps
    localparam int OUT_ST   = POLY_ST + 2 * HORNER;                // output register stage
    localparam int NST      = OUT_ST + 1;

    // stage valid bits and per-stage advance enables
    logic [NST-1:0]  v_reg;
    logic [NST-1:0]  en;

    scp_pkg::q60_t   x_arg [2];        // lane 0 sine, lane 1 cosine
    scp_pkg::q60_t   p_poly [2];
    scp_pkg::side_t  front_side;
    scp_pkg::side_t  side_reg [FRONT_ST:OUT_ST-1];

    // A stage may advance if any stage at or after it is empty, or the output
    // word leaves this cycle.
    always_comb
    begin
        for (int k = 0; k < NST; k++)
        begin
            en[k] = out_ready | ~(&(v_reg | NST'((64'd1 << k) - 64'd1)));
        end
    end

    assign in_ready  = en[0];
    assign out_valid = v_reg[NST-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else
        begin
            if (en[0])
                v_reg[0] <= in_valid;
            for (int k = 1; k < NST; k++)
            begin
                if (en[k])
                    v_reg[k] <= v_reg[k-1];
            end
        end
    end

    // Angle reduction
    scp_front #(
        .ANGLE_FRAC_BITS(ANGLE_FRAC_BITS)
    ) u_front (
        .clk     (clk),
        .en      (en[FRONT_ST-1:0]),
        .angle   (angle),
        .is_last (is_last),
        .x_sin   (x_arg[0]),
        .x_cos   (x_arg[1]),
        .side    (front_side)
    );

    // Carry quadrant and batch marker beside the polynomial lanes
    always_ff @(posedge clk)
    begin
        if (en[FRONT_ST])
            side_reg[FRONT_ST] <= front_side;
        for (int k = FRONT_ST + 1; k < OUT_ST; k++)
        begin
            if (en[k])
                side_reg[k] <= side_reg[k-1];
        end
    end

    // Two polynomial lanes: square the argument, then Horner from the top term
    for (genvar ln = 0; ln < 2; ln++)
    begin : g_lane
        scp_pkg::q60_t x2_w;
        scp_pkg::q60_t acc_w [HORNER];
        scp_pkg::q60_t bq_w [HORNER-1];

        scp_mac u_sq (
            .clk (clk),
            .en  (en[SQ_ST +: 2]),
            .a   (x_arg[ln]),
            .b   (x_arg[ln]),
            .c   ('0),
            .y   (x2_w),
            .b_q ()
        );

        for (genvar j = 0; j < HORNER; j++)
        begin : g_step
            if (j == 0)
            begin : g_first
                scp_mac u_mac (
                    .clk (clk),
                    .en  (en[POLY_ST +: 2]),
                    .a   (scp_pkg::POLY_COEF[HORNER]),
                    .b   (x2_w),
                    .c   (scp_pkg::POLY_COEF[HORNER-1]),
                    .y   (acc_w[0]),
                    .b_q (bq_w[0])
                );
            end
            else if (j < HORNER - 1)
            begin : g_mid
                scp_mac u_mac (
                    .clk (clk),
                    .en  (en[POLY_ST + 2*j +: 2]),
                    .a   (acc_w[j-1]),
                    .b   (bq_w[j-1]),
                    .c   (scp_pkg::POLY_COEF[HORNER-1-j]),
                    .y   (acc_w[j]),
                    .b_q (bq_w[j])
                );
            end
            else
            begin : g_last
                scp_mac u_mac (
                    .clk (clk),
                    .en  (en[POLY_ST + 2*j +: 2]),
                    .a   (acc_w[j-1]),
                    .b   (bq_w[j-1]),
                    .c   (scp_pkg::POLY_COEF[HORNER-1-j]),
                    .y   (acc_w[j]),
                    .b_q ()
                );
            end
        end

        assign p_poly[ln] = acc_w[HORNER-1];
    end

    // Clamp, sign and scale into the output register
    scp_round #(
        .OUT_FRAC_BITS(OUT_FRAC_BITS)
    ) u_round (
        .clk      (clk),
        .en       (en[OUT_ST]),
        .p_sin    (p_poly[0]),
        .p_cos    (p_poly[1]),
        .side     (side_reg[OUT_ST-1]),
        .sine     (sine),
        .cosine   (cosine),
        .last_out (last_out)
    );

    // An accepted word occupies the first stage on the next cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> v_reg[0])
        else $error("accepted word missing from first stage");

    // The input is never held off while some stage is empty
    assert property (@(posedge clk) disable iff (!rst_n)
        !(&v_reg) |-> in_ready)
        else $error("input stalled with an empty stage");

    // Without an accept or a delivery the number of words in flight holds
    assert property (@(posedge clk) disable iff (!rst_n)
        (!(in_valid && in_ready) && !(out_valid && out_ready))
        |=> ($countones(v_reg) == $past($countones(v_reg))))
        else $error("word lost or duplicated inside the pipeline");

endmodule

/* hw/rtl/scp_front.sv */
// Angle reduction front end: turns, quadrant and the two polynomial arguments.
// Four register stages; uses scp_pkg.
module scp_front #(
    parameter int ANGLE_FRAC_BITS = 24
) (
    input  logic            clk,
    input  logic [3:0]      en,
    input  logic [31:0]     angle,
    input  logic            is_last,
    output scp_pkg::q60_t   x_sin,
    output scp_pkg::q60_t   x_cos,
    output scp_pkg::side_t  side
);

    localparam int PHASE_LSB = ANGLE_FRAC_BITS + 32;

    // stage 0: signed angle times the two halves of 1/(2*pi)
    logic signed [64:0] plo_reg, phi_reg;
    logic               last0_reg;
    // stage 1: phase
    logic [1:0]         quad1_reg;
    logic [29:0]        frac1_reg;
    logic               last1_reg;
    // stage 2: fraction times pi/2
    logic [61:0]        pm_lo_reg;
    logic [58:0]        pm_hi_reg;
    scp_pkg::side_t     side2_reg;
    // stage 3: arguments
    scp_pkg::q60_t      x_sin_reg, x_cos_reg;
    scp_pkg::side_t     side3_reg;

    logic signed [64:0] plo_next, phi_next;
    logic [127:0]       prod;
    logic [31:0]        phase;
    logic [61:0]        pm_lo_next;
    logic [58:0]        pm_hi_next;
    logic [90:0]        m_full, m_ceil;
    scp_pkg::q60_t      near_arg, far_arg;

    always_comb
    begin
        plo_next = $signed({{33{angle[31]}}, angle}) * $signed({33'd0, scp_pkg::INV_TWO_PI[31:0]});
        phi_next = $signed({{33{angle[31]}}, angle}) * $signed({33'd0, scp_pkg::INV_TWO_PI[63:32]});

        prod  = {{31{phi_reg[64]}}, phi_reg, 32'd0} + {{63{plo_reg[64]}}, plo_reg};
        phase = prod[PHASE_LSB +: 32];

        pm_lo_next = 62'(frac1_reg) * 62'(scp_pkg::HALF_PI_LO);
        pm_hi_next = 59'(frac1_reg) * 59'(scp_pkg::HALF_PI_HI);

        m_full   = {pm_hi_reg, 32'd0} + {29'd0, pm_lo_reg};
        m_ceil   = m_full + {61'd0, 30'h3FFF_FFFF};
        near_arg = {3'd0, m_full[90:30]};
        far_arg  = scp_pkg::HALF_PI - {3'd0, m_ceil[90:30]};
    end

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            plo_reg   <= plo_next;
            phi_reg   <= phi_next;
            last0_reg <= is_last;
        end
        if (en[1])
        begin
            quad1_reg <= phase[31:30];
            frac1_reg <= phase[29:0];
            last1_reg <= last0_reg;
        end
        if (en[2])
        begin
            pm_lo_reg      <= pm_lo_next;
            pm_hi_reg      <= pm_hi_next;
            side2_reg.quad <= quad1_reg;
            side2_reg.last <= last1_reg;
        end
        if (en[3])
        begin
            // odd quadrants measure the cosine from the far boundary
            x_cos_reg <= side2_reg.quad[0] ? far_arg : near_arg;
            x_sin_reg <= side2_reg.quad[0] ? near_arg : far_arg;
            side3_reg <= side2_reg;
        end
    end

    assign x_sin = x_sin_reg;
    assign x_cos = x_cos_reg;
    assign side  = side3_reg;

endmodule

/* hw/rtl/scp_mac.sv */
// One Q60 multiply-add step: y = trunc_to_zero(a*b / 2^60) + c, over two stages.
// Partial products 32x32 in the first stage, sum and add in the second; uses scp_pkg.
module scp_mac (
    input  logic          clk,
    input  logic [1:0]    en,
    input  scp_pkg::q60_t a,
    input  scp_pkg::q60_t b,
    input  scp_pkg::q60_t c,
    output scp_pkg::q60_t y,
    output scp_pkg::q60_t b_q
);

    logic [63:0]   p00_reg, p01_reg, p10_reg, p11_reg;
    logic          neg_reg;
    scp_pkg::q60_t c_reg, b1_reg;
    scp_pkg::q60_t y_reg, b2_reg;

    logic [63:0]   a_mag, b_mag;
    logic [64:0]   mid;
    logic [127:0]  sum;
    logic [63:0]   r_mag;
    scp_pkg::q60_t y_next;

    always_comb
    begin
        a_mag  = a[63] ? (64'd0 - a) : a;
        b_mag  = b[63] ? (64'd0 - b) : b;
        mid    = {1'b0, p01_reg} + {1'b0, p10_reg};
        sum    = {p11_reg, 64'd0} + {31'd0, mid, 32'd0} + {64'd0, p00_reg};
        r_mag  = {1'b0, sum[122:60]};
        y_next = (neg_reg ? (64'd0 - r_mag) : r_mag) + c_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            p00_reg <= 64'(a_mag[31:0])  * 64'(b_mag[31:0]);
            p01_reg <= 64'(a_mag[31:0])  * 64'(b_mag[63:32]);
            p10_reg <= 64'(a_mag[63:32]) * 64'(b_mag[31:0]);
            p11_reg <= 64'(a_mag[63:32]) * 64'(b_mag[63:32]);
            neg_reg <= a[63] ^ b[63];
            c_reg   <= c;
            b1_reg  <= b;
        end
        if (en[1])
        begin
            y_reg  <= y_next;
            b2_reg <= b1_reg;
        end
    end

    assign y   = y_reg;
    assign b_q = b2_reg;

endmodule

/* hw/rtl/scp_round.sv */
// Output stage: clamp to +-1, apply quadrant sign, scale to the output format.
// Holds the output register; uses scp_pkg.
module scp_round #(
    parameter int OUT_FRAC_BITS = 30
) (
    input  logic           clk,
    input  logic           en,
    input  scp_pkg::q60_t  p_sin,
    input  scp_pkg::q60_t  p_cos,
    input  scp_pkg::side_t side,
    output logic [31:0]    sine,
    output logic [31:0]    cosine,
    output logic           last_out
);

    localparam int          SH  = (OUT_FRAC_BITS <= 60) ? (60 - OUT_FRAC_BITS) : 0;
    localparam int          SL  = (OUT_FRAC_BITS > 60) ? ((OUT_FRAC_BITS - 60) % 4) : 0;
    localparam logic [63:0] RND = (64'd1 << SH) >> 1;

    logic [31:0] sine_reg, cosine_reg;
    logic        last_reg;

    function automatic logic [31:0] to_out(input scp_pkg::q60_t p, input logic negate);
        scp_pkg::q60_t pc;
        logic          neg;
        logic [63:0]   mag;
        logic [63:0]   res;
        begin
            if (p > scp_pkg::ONE_Q60)
                pc = scp_pkg::ONE_Q60;
            else if (p < scp_pkg::NEG_ONE_Q60)
                pc = scp_pkg::NEG_ONE_Q60;
            else
                pc = p;
            neg = negate ^ pc[63];
            mag = pc[63] ? (64'd0 - pc) : pc;
            mag = ((mag + RND) >> SH) << SL;
            res = neg ? (64'd0 - mag) : mag;
            to_out = res[31:0];
        end
    endfunction

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sine_reg   <= to_out(p_sin, side.quad[1]);
            cosine_reg <= to_out(p_cos, side.quad[1] ^ side.quad[0]);
            last_reg   <= side.last;
        end
    end

    assign sine     = sine_reg;
    assign cosine   = cosine_reg;
    assign last_out = last_reg;

endmodule

/* tb/testbench.sv */
`timescale 1ns / 100ps
// Self-checking testbench for sine_cosine_polynomial_unit_top: angle words in, sine/cosine out.
// Needs only the RTL of the unit; carries its own bit-exact predictor of the arithmetic.

module testbench;

    // Default formats of the unit: Q8.24 angle in, Q1.30 sine and cosine out
    localparam int ANGLE_FB = 24;
    localparam int OUT_FB   = 30;

    // Clock and reset
    localparam int RESET_CYCLES = 7;
    // Cycles after the last expected word in which nothing more may appear;
    // the pipeline is 21 stages deep
    localparam int DRAIN_CYCLES = 32;
    // Cycles with no word moved on either side before the run is abandoned
    localparam int QUIET_LIMIT  = 2000;
    localparam int IDLE_PCT     = 14;
    localparam int RANDOM_WORDS = 1100;
    // Stimulus positions between which neither side idles
    localparam int CALM_FIRST   = 450;
    localparam int CALM_LAST    = 750;
    localparam int MAX_REPORTS  = 10;

    // Arithmetic constants, Q0.64 and Q60
    localparam logic [63:0]        INV_TWO_PI_Q64 = 64'h28BE_60DB_9391_054A;
    localparam logic signed [63:0] HALF_PI_Q60    = 64'sh1921_FB54_442D_1847;
    localparam logic signed [63:0] Q60_ONE        = 64'sh1000_0000_0000_0000;
    // pi/2 in angle units (Q8.24), used to aim stimulus at quadrant boundaries
    localparam real QUARTER_TURN_RAW = 26353589.299;

    // One sine/cosine result word
    typedef struct {
        logic [31:0] sine;
        logic [31:0] cosine;
        logic        last;
    } trig_word_t;

    // One row of stimulus; typed rows carry their expected sine and cosine
    typedef struct {
        logic [31:0] angle;
        logic        last;
        bit          typed;
        logic [31:0] exp_sine;
        logic [31:0] exp_cosine;
    } angle_row_t;

    logic        clk      = 1'b0;
    logic        rst_n    = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_ready;
    logic [31:0] angle    = '0;
    logic        is_last  = 1'b0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    logic [31:0] sine;
    logic [31:0] cosine;
    logic        last_out;

    // Expectation that travels with the word on the input port
    bit          drive_typed      = 1'b0;
    logic [31:0] drive_exp_sine   = '0;
    logic [31:0] drive_exp_cosine = '0;

    angle_row_t angle_rows[$];
    trig_word_t trig_expected_q[$];

    bit calm = 1'b0;
    int directed_count  = 0;
    int angles_taken    = 0;
    int words_checked   = 0;
    int batch_ends      = 0;
    int fault_count     = 0;
    int quiet_cycles    = 0;
    int quad_hits [4]   = '{0, 0, 0, 0};

    sine_cosine_polynomial_unit_top #(
        .ANGLE_FRAC_BITS (ANGLE_FB),
        .OUT_FRAC_BITS   (OUT_FB)
    ) uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .angle     (angle),
        .is_last   (is_last),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .sine      (sine),
        .cosine    (cosine),
        .last_out  (last_out)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------

    // Q60 product: multiply magnitudes exactly, drop 60 bits (toward zero),
    // then restore the sign
    function automatic logic signed [63:0] q60_mul(input logic signed [63:0] a,
                                                   input logic signed [63:0] b);
        logic [63:0]  mag_a;
        logic [63:0]  mag_b;
        logic [127:0] prod;
        logic [63:0]  mag_r;
        mag_a = a[63] ? 64'd0 - a : a;
        mag_b = b[63] ? 64'd0 - b : b;
        prod  = {64'd0, mag_a} * {64'd0, mag_b};
        mag_r = {1'b0, prod[122:60]};
        return (a[63] ^ b[63]) ? 64'd0 - mag_r : mag_r;
    endfunction

    // Even cosine polynomial terms, Q60, lowest order first
    function automatic logic signed [63:0] horner_coef(input int k);
        case (k)
            0:       return 64'sd1152921504606844748;
            1:       return -64'sd576460752303307800;
            2:       return 64'sd48038396024299631;
            3:       return -64'sd1601279864309835;
            4:       return 64'sd28594278246078;
            5:       return -64'sd317709838487;
            6:       return 64'sd2404801474;
            default: return -64'sd12775196;
        endcase
    endfunction

    function automatic logic signed [63:0] cos_poly(input logic signed [63:0] x);
        logic signed [63:0] x2;
        logic signed [63:0] acc;
        x2  = q60_mul(x, x);
        acc = horner_coef(7);
        for (int k = 6; k >= 0; k--)
            acc = q60_mul(acc, x2) + horner_coef(k);
        return acc;
    endfunction

    // Clamp to +-1.0, apply the quadrant sign, round half away from zero
    // into the output format and keep the low 32 bits
    function automatic logic [31:0] to_out_fixed(input logic signed [63:0] p,
                                                 input logic negate);
        logic signed [63:0] c;
        logic               neg;
        logic [63:0]        mag;
        logic [63:0]        v;
        c = p;
        if (c > Q60_ONE)
            c = Q60_ONE;
        if (c < -Q60_ONE)
            c = -Q60_ONE;
        neg = negate ^ c[63];
        mag = c[63] ? 64'd0 - c : c;
        if (OUT_FB < 60)
            mag = (mag + (64'd1 << (59 - OUT_FB))) >> (60 - OUT_FB);
        else if (OUT_FB > 60)
            mag = mag << ((OUT_FB - 60) & 3);
        v = neg ? 64'd0 - mag : mag;
        return v[31:0];
    endfunction

    function automatic trig_word_t sincos_predict(input logic [31:0] a, input logic lst,
                                                  output logic [1:0] quad);
        logic [127:0]       prod;
        logic [31:0]        phase;
        logic signed [63:0] t;
        logic signed [63:0] near_arg;
        logic signed [63:0] far_arg;
        trig_word_t         w;
        // Signed angle times unsigned 1/(2*pi); the wrap of the 128-bit
        // product gives the right phase for negative angles too
        prod     = {{96{a[31]}}, a} * {64'd0, INV_TWO_PI_Q64};
        phase    = prod[ANGLE_FB + 32 +: 32];
        quad     = phase[31:30];
        t        = {4'd0, phase[29:0], 30'd0};
        near_arg = q60_mul(t, HALF_PI_Q60);
        far_arg  = q60_mul(Q60_ONE - t, HALF_PI_Q60);
        w.sine   = to_out_fixed(cos_poly(quad[0] ? near_arg : far_arg), quad[1]);
        w.cosine = to_out_fixed(cos_poly(quad[0] ? far_arg : near_arg), quad[1] ^ quad[0]);
        w.last   = lst;
        return w;
    endfunction

    // ------------------------------------------------------------------
    // Stimulus table
    // ------------------------------------------------------------------

    task automatic add_row(input logic [31:0] a, input logic lst, input bit typed,
                           input logic [31:0] s, input logic [31:0] c);
        angle_row_t r;
        r.angle      = a;
        r.last       = lst;
        r.typed      = typed;
        r.exp_sine   = s;
        r.exp_cosine = c;
        angle_rows.push_back(r);
    endtask

    task automatic build_rows();
        int          sel;
        int          k;
        int          off;
        logic [31:0] a;
        // Zero angle: sine rounds to zero and cosine to exactly one
        add_row(32'h0000_0000, 1'b0, 1'b1, 32'h0000_0000, 32'h4000_0000);
        add_row(32'h0000_0000, 1'b1, 1'b1, 32'h0000_0000, 32'h4000_0000);
        // Extremes of the angle field; far out of range, the phase wraps
        add_row(32'h0000_0001, 1'b0, 1'b0, '0, '0);
        add_row(32'hFFFF_FFFF, 1'b0, 1'b0, '0, '0);
        add_row(32'h7FFF_FFFF, 1'b1, 1'b0, '0, '0);
        add_row(32'h8000_0000, 1'b0, 1'b0, '0, '0);
        add_row(32'h8000_0001, 1'b0, 1'b0, '0, '0);
        add_row(32'h0100_0000, 1'b0, 1'b0, '0, '0);
        add_row(32'hFF00_0000, 1'b1, 1'b0, '0, '0);
        add_row(32'h5555_5555, 1'b0, 1'b0, '0, '0);
        add_row(32'hAAAA_AAAA, 1'b0, 1'b0, '0, '0);
        // Angles next to the multiples of pi/2, around the quadrant boundaries
        add_row(32'd26353588, 1'b0, 1'b0, '0, '0);
        add_row(32'd26353589, 1'b0, 1'b0, '0, '0);
        add_row(32'd26353590, 1'b1, 1'b0, '0, '0);
        add_row(32'd52707178, 1'b0, 1'b0, '0, '0);
        add_row(32'd52707179, 1'b0, 1'b0, '0, '0);
        add_row(32'd79060768, 1'b0, 1'b0, '0, '0);
        add_row(32'd79060769, 1'b1, 1'b0, '0, '0);
        add_row(32'd105414357, 1'b0, 1'b0, '0, '0);
        add_row(32'd105414358, 1'b0, 1'b0, '0, '0);
        add_row(-32'sd26353589, 1'b0, 1'b0, '0, '0);
        add_row(-32'sd105414357, 1'b1, 1'b0, '0, '0);
        directed_count = angle_rows.size();

        // Random angles: the full field, aim at quadrant boundaries, and
        // one turn either side of zero
        for (int i = 0; i < RANDOM_WORDS; i++)
        begin
            sel = $urandom_range(0, 99);
            if (sel < 45)
                a = $urandom;
            else if (sel < 75)
            begin
                k   = $urandom_range(0, 162);
                k   = k - 81;
                off = $urandom_range(0, 128);
                off = off - 64;
                a   = $rtoi(k * QUARTER_TURN_RAW) + off;
            end
            else
            begin
                k = $urandom_range(0, 2 * 105414357);
                a = k - 105414357;
            end
            add_row(a, ($urandom_range(0, 15) == 0), 1'b0, '0, '0);
        end
    endtask

    // ------------------------------------------------------------------
    // Output side: drop ready at random, never during the calm stretch
    // ------------------------------------------------------------------
    always @(posedge clk)
        out_ready <= calm || ($urandom_range(0, 99) >= IDLE_PCT);

    // ------------------------------------------------------------------
    // Scoreboard: both handshakes are sampled at the same edge, so the
    // values seen are those that held just before it
    // ------------------------------------------------------------------
    task automatic report_field(input string field, input logic [31:0] want,
                                input logic [31:0] got);
        fault_count++;
        if (fault_count <= MAX_REPORTS)
            $display("word %0d: %s expected %h, got %h", words_checked, field, want, got);
    endtask

    always @(posedge clk)
    begin
        trig_word_t want;
        logic [1:0] quad;
        if (in_valid && in_ready && out_valid && out_ready)
            quiet_cycles <= 0;
        else if ((in_valid && in_ready) || (out_valid && out_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;

        if (rst_n && in_valid && in_ready)
        begin
            want = sincos_predict(angle, is_last, quad);
            if (drive_typed)
            begin
                want.sine   = drive_exp_sine;
                want.cosine = drive_exp_cosine;
            end
            trig_expected_q.push_back(want);
            quad_hits[quad]++;
            angles_taken++;
            if (is_last)
                batch_ends++;
        end

        if (rst_n && out_valid && out_ready)
        begin
            if (trig_expected_q.size() == 0)
            begin
                fault_count++;
                if (fault_count <= MAX_REPORTS)
                    $display("unexpected word: sine %h cosine %h last %b",
                             sine, cosine, last_out);
            end
            else
            begin
                want = trig_expected_q.pop_front();
                if (sine !== want.sine)
                    report_field("sine", want.sine, sine);
                if (cosine !== want.cosine)
                    report_field("cosine", want.cosine, cosine);
                if (last_out !== want.last)
                    report_field("last_out", {31'd0, want.last}, {31'd0, last_out});
                words_checked++;
            end
        end
    end

    // Watchdog: abandon the run when nothing moves for too long
    initial
    begin
        while (quiet_cycles < QUIET_LIMIT)
            @(posedge clk);
        $display("watchdog: no word moved for %0d cycles", QUIET_LIMIT);
        $display("** sine_cosine_polynomial_unit_top: FAILED **");
        $finish;
    end

    // ------------------------------------------------------------------
    // Input side and end of run
    // ------------------------------------------------------------------
    initial
    begin
        int idx;
        build_rows();

        // Hold reset low, then release it once
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;

        // Walk the table; a new word goes on the port only when the port
        // is empty or its word is taken at this edge
        idx = 0;
        while (idx < angle_rows.size())
        begin
            @(posedge clk);
            if (!in_valid || in_ready)
            begin
                calm = (idx >= CALM_FIRST) && (idx < CALM_LAST);
                if (!calm && $urandom_range(0, 99) < IDLE_PCT)
                    in_valid <= 1'b0;
                else
                begin
                    angle            <= angle_rows[idx].angle;
                    is_last          <= angle_rows[idx].last;
                    drive_typed      <= angle_rows[idx].typed;
                    drive_exp_sine   <= angle_rows[idx].exp_sine;
                    drive_exp_cosine <= angle_rows[idx].exp_cosine;
                    in_valid         <= 1'b1;
                    idx++;
                end
            end
        end
        // Hold the last word until it is taken, then drop valid
        do
            @(posedge clk);
        while (!in_ready);
        in_valid <= 1'b0;
        calm = 1'b0;

        // Drain: wait for every expected word, then watch for strays
        while (trig_expected_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (trig_expected_q.size() != 0)
        begin
            fault_count += trig_expected_q.size();
            $display("%0d expected words never arrived", trig_expected_q.size());
        end

        $display("Sent %0d angles (%0d from the directed table), %0d batch ends; checked %0d words.",
                 angles_taken, directed_count, batch_ends, words_checked);
        $display("Quadrant hits 0/1/2/3: %0d/%0d/%0d/%0d; faults: %0d.",
                 quad_hits[0], quad_hits[1], quad_hits[2], quad_hits[3], fault_count);
        if (fault_count == 0)
            $display("** sine_cosine_polynomial_unit_top: PASSED **");
        else
            $display("** sine_cosine_polynomial_unit_top: FAILED **");
        $finish;
    end

endmodule
